/* src/srp_pkg.sv */
// Shared types and constants for the shelf rectangle packer.
`default_nettype none

package srp_pkg;

  // Widths of the item fields and configuration registers.
  localparam int unsigned DimW    = 14;
  localparam int unsigned GapW    = 8;
  localparam int unsigned CfgIdxW = 2;
  // Clamped atlas sizes and shelf height carry one more bit (up to 32767).
  localparam int unsigned ExtW    = DimW + 1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ATLAS_WIDTH  = 2'd0,
    CFG_ATLAS_HEIGHT = 2'd1,
    CFG_GAP          = 2'd2
  } cfg_idx_e;

  localparam logic [DimW-1:0] AtlasWidthRst  = 14'd1024;
  localparam logic [DimW-1:0] AtlasHeightRst = 14'd1024;
  localparam logic [GapW-1:0] GapRst         = 8'd0;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_PLACED    = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NO_FIT    = 2'd3
  } status_e;

  typedef struct packed {
    logic [DimW-1:0] rect_width;
    logic [DimW-1:0] rect_height;
    logic            start_set;
  } srp_in_t;

  typedef struct packed {
    logic            placed;
    status_e         status;
    logic [DimW-1:0] pos_x;
    logic [DimW-1:0] pos_y;
  } srp_out_t;

  // Configuration as the placement logic sees it (atlas sizes clamped).
  typedef struct packed {
    logic [ExtW-1:0] atlas_w;
    logic [ExtW-1:0] atlas_h;
    logic [GapW-1:0] gap;
  } srp_cfg_t;

  typedef struct packed {
    logic [DimW-1:0] cursor_x;
    logic [ExtW-1:0] row_top;
    logic [ExtW-1:0] shelf_height;
    logic            atlas_full;
  } srp_state_t;

endpackage

`default_nettype wire

/* src/srp_cfg_regs.sv */
// Configuration registers of the shelf rectangle packer with atlas size clamp.
`default_nettype none

module srp_cfg_regs #(
  parameter int unsigned MAX_DIM = 8192
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [srp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [srp_pkg::DimW-1:0]          cfg_data_i,
  output srp_pkg::srp_cfg_t                      cfg_o
);

  localparam logic [srp_pkg::ExtW-1:0] ClampDim = srp_pkg::ExtW'(MAX_DIM);

  logic [srp_pkg::DimW-1:0] atlas_w_q, atlas_h_q;
  logic [srp_pkg::GapW-1:0] gap_q;
  logic [srp_pkg::ExtW-1:0] aw_ext, ah_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= srp_pkg::AtlasWidthRst;
      atlas_h_q <= srp_pkg::AtlasHeightRst;
      gap_q     <= srp_pkg::GapRst;
    end else if (cfg_we_i) begin
      case (srp_pkg::cfg_idx_e'(cfg_index_i))
        srp_pkg::CFG_ATLAS_WIDTH:  atlas_w_q <= cfg_data_i;
        srp_pkg::CFG_ATLAS_HEIGHT: atlas_h_q <= cfg_data_i;
        srp_pkg::CFG_GAP:          gap_q     <= cfg_data_i[srp_pkg::GapW-1:0];
        default: ;
      endcase
    end
  end

  assign aw_ext = {1'b0, atlas_w_q};
  assign ah_ext = {1'b0, atlas_h_q};

  always_comb begin
    cfg_o.atlas_w = (aw_ext > ClampDim) ? ClampDim : aw_ext;
    cfg_o.atlas_h = (ah_ext > ClampDim) ? ClampDim : ah_ext;
    cfg_o.gap     = gap_q;
  end

endmodule

`default_nettype wire

/* src/srp_place.sv */
// Placement decision for one rectangle against the current shelf state.
`default_nettype none

module srp_place (
  input  wire srp_pkg::srp_cfg_t   cfg_i,
  input  wire srp_pkg::srp_in_t    item_i,
  input  wire srp_pkg::srp_state_t state_i,
  output srp_pkg::srp_state_t      state_o,
  output srp_pkg::srp_out_t        result_o
);

  localparam int unsigned SumW = srp_pkg::ExtW + 2;
  localparam int unsigned CurW = srp_pkg::DimW + 2;
  localparam logic [srp_pkg::ExtW-1:0] RowMax = '1;
  localparam logic [srp_pkg::DimW-1:0] CurMax = '1;

  function automatic logic [srp_pkg::ExtW-1:0] sat_row(input logic [SumW-1:0] v);
    return (v > SumW'(RowMax)) ? RowMax : v[srp_pkg::ExtW-1:0];
  endfunction

  srp_pkg::srp_state_t st0, st1, st2;
  logic [srp_pkg::ExtW-1:0] wg, hg;
  logic [SumW-1:0]          top1, bottom1, top2;
  logic [CurW-1:0]          right2, cur_next;
  logic                     too_large, new_shelf, overflow, wrap, fits;

  always_comb begin
    // Drop all packing state when a new atlas starts.
    st0 = item_i.start_set ? '0 : state_i;

    wg = {1'b0, item_i.rect_width}  + srp_pkg::ExtW'(cfg_i.gap);
    hg = {1'b0, item_i.rect_height} + srp_pkg::ExtW'(cfg_i.gap);
    too_large = (wg > cfg_i.atlas_w) || (hg > cfg_i.atlas_h);

    // Open a new shelf below the current one when the rectangle is taller.
    new_shelf = hg > st0.shelf_height;
    top1      = SumW'(st0.row_top) + SumW'(st0.shelf_height);
    bottom1   = top1 + SumW'(hg);
    overflow  = new_shelf && (bottom1 > SumW'(cfg_i.atlas_h));
    st1 = st0;
    if (new_shelf) begin
      st1.row_top      = sat_row(top1);
      st1.cursor_x     = '0;
      st1.shelf_height = hg;
    end

    // Wrap to a new row when the rectangle runs past the right edge.
    wrap = (CurW'(st1.cursor_x) + CurW'(wg)) > CurW'(cfg_i.atlas_w);
    top2 = SumW'(st1.row_top) + SumW'(st1.shelf_height);
    st2 = st1;
    if (wrap) begin
      st2.cursor_x     = '0;
      st2.row_top      = sat_row(top2);
      st2.shelf_height = hg;
    end

    right2 = CurW'(st2.cursor_x) + CurW'(item_i.rect_width);
    fits   = ((SumW'(st2.row_top) + SumW'(item_i.rect_height)) <= SumW'(cfg_i.atlas_h))
             && (right2 <= CurW'(cfg_i.atlas_w));
    cur_next = CurW'(st2.cursor_x) + CurW'(wg);

    state_o         = st0;
    result_o.placed = 1'b0;
    result_o.status = srp_pkg::STATUS_NO_FIT;
    result_o.pos_x  = '0;
    result_o.pos_y  = '0;

    if (st0.atlas_full) begin
      result_o.status = srp_pkg::STATUS_FULL;
    end else if (too_large) begin
      result_o.status = srp_pkg::STATUS_TOO_LARGE;
    end else if (overflow) begin
      state_o.atlas_full = 1'b1;
      result_o.status    = srp_pkg::STATUS_FULL;
    end else if (fits) begin
      state_o          = st2;
      state_o.cursor_x = (cur_next > CurW'(CurMax)) ? CurMax
                                                    : cur_next[srp_pkg::DimW-1:0];
      if (hg > st2.shelf_height) begin
        state_o.shelf_height = hg;
      end
      result_o.placed = 1'b1;
      result_o.status = srp_pkg::STATUS_PLACED;
      result_o.pos_x  = st2.cursor_x;
      result_o.pos_y  = st2.row_top[srp_pkg::DimW-1:0];
    end else begin
      // Keep the shelf and row moves even though nothing was placed.
      state_o = st2;
    end
  end

endmodule

`default_nettype wire

/* src/shelf_rect_packer.sv */
// Top level of the shelf rectangle packer: input register, placement, result register.
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) carries one rectangle per
//   item: width, height and a start flag that opens a fresh atlas before it.
//   Output channel (out_valid_o / out_ready_i / out_item_o) returns exactly one
//   result per item: placed flag, status code and the top-left corner.
//   Configuration: cfg_we_i writes cfg_data_i into the register chosen by
//   cfg_index_i (atlas width, atlas height, gap); write only while idle.
// Path: an accepted item waits in the input register, then the placement logic
//   settles into the result register, which raises out_valid_o; a stalled
//   receiver can hold the item in the input register in between.
// Throughput: one item per cycle while the receiver keeps out_ready_i high. The shelf
//   state (cursor, row top, shelf height, full flag) updates in the same cycle the
//   result is registered, so the next item sees it at once.
// Reset: clears both stages and the shelf state; configuration returns to a
//   1024 x 1024 atlas with no gap.
// Stall: while out_ready_i is low the result register holds its item; one more
//   item may enter the input register, after which in_ready_o drops until the
//   result is taken. At most two items are held while the receiver stalls.
`default_nettype none

module shelf_rect_packer #(
  parameter int unsigned MAX_DIM = 8192
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [srp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [srp_pkg::DimW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire srp_pkg::srp_in_t            in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output srp_pkg::srp_out_t                out_item_o
);

  srp_pkg::srp_cfg_t   cfg;
  srp_pkg::srp_state_t state_q, state_d;
  srp_pkg::srp_in_t    in_item_q;
  srp_pkg::srp_out_t   out_item_q, result;
  logic                in_valid_q, out_valid_q;
  logic                out_adv, in_fire, move;

  srp_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  srp_place u_place (
    .cfg_i    (cfg),
    .item_i   (in_item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Result register frees up when empty or being taken this cycle.
  assign out_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign move       = in_valid_q && out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
      // Advance the shelf state only when the item leaves the input register.
      if (move) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= in_item_i;
    end
    if (move) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* src/srp_checker.sv */
// Port-level checks for the shelf rectangle packer, bound to the top level.
`default_nettype none

module srp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire srp_pkg::srp_out_t  out_item_o
);

  // Input side only backs up when a result is waiting on a stalled receiver.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("in_ready low without a stalled result");

  a_placed_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.placed == (out_item_o.status == srp_pkg::STATUS_PLACED)))
    else $error("placed flag disagrees with status");

  a_unplaced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.placed) |-> (out_item_o.pos_x == '0 && out_item_o.pos_y == '0))
    else $error("unplaced result carries a position");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind shelf_rect_packer srp_checker u_srp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
